@@ design/spi_nor_flash_slave_unit_assert.svh @@
// Assertion macros used by the flash slave controller.
// No dependencies.
`ifndef SPI_NOR_FLASH_SLAVE_UNIT_ASSERT_SVH
`define SPI_NOR_FLASH_SLAVE_UNIT_ASSERT_SVH
`define SNF_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SNF_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ design/snf_pkg.sv @@
// Package for the SPI NOR flash slave: sizes, opcodes, controller/datapath types.
// No dependencies.
package snf_pkg;
    localparam int FLASH_BYTES = 262144;
    localparam int PAGE_BYTES = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int BLOCK32_BYTES = 32768;
    localparam int BLOCK64_BYTES = 65536;
    localparam int COMMAND_LEN = 5;
    localparam int AW = $clog2(FLASH_BYTES);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int CW = $clog2(COMMAND_LEN + 1);

    localparam logic [7:0] MFR_ID = 8'hEF;
    localparam logic [7:0] DEV_ID = 8'h11;
    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_PP = 8'h02;
    localparam logic [7:0] OP_SE = 8'h20;
    localparam logic [7:0] OP_BE32 = 8'h52;
    localparam logic [7:0] OP_BE64 = 8'hD8;
    localparam logic [7:0] OP_CE = 8'hC7;
    localparam logic [7:0] OP_CE2 = 8'h60;
    localparam logic [7:0] OP_ID = 8'h90;
    localparam logic [7:0] OP_UID = 8'h4B;

    localparam logic [1:0] FN_BYTE = 2'd0;
    localparam logic [1:0] FN_ASSERT = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_LONG = 2'd2;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_READ,    // issue array read at cursor
        DP_FILL,    // write 0xFF at sweep address
        DP_LOADPG,  // read array for page buffer
        DP_PROG     // AND page into array
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [AW:0] addr;   // extra bit marks past end
        logic [PW:0] pidx;
    } dp_cmd_t;

    typedef struct packed {
        logic [7:0] rdata;
    } dp_stat_t;
endpackage

@@ design/snf_datapath.sv @@
// Flash array and page buffer memories with read/fill/program operations.
// Depends on snf_pkg.
module snf_datapath
    import snf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic       pb_we,
    input  logic [PW-1:0] pb_waddr,
    input  logic [7:0] pb_wdata,
    output dp_stat_t   stat
);
    logic [7:0] flash_mem [FLASH_BYTES];
    logic [7:0] page_mem [PAGE_BYTES];
    logic [7:0] flash_q_reg;
    logic [7:0] page_q_reg;
    logic       past_reg;
    logic [7:0] ld_data_reg;
    logic [PW-1:0] ld_idx_reg;
    logic       ld_reg;
    logic       prog_reg;
    logic [AW-1:0] prog_addr_reg;
    logic [AW-1:0] a;

    assign a = cmd.addr[AW-1:0];

    // program: array and page bytes are registered, then their AND is written back from those registers
    always_ff @(posedge clk)
    begin
        flash_q_reg <= flash_mem[a];
        page_q_reg <= page_mem[cmd.pidx[PW-1:0]];
        if (cmd.op == DP_FILL && !cmd.addr[AW])
        begin
            flash_mem[a] <= 8'hFF;
        end
        else if (prog_reg)
        begin
            flash_mem[prog_addr_reg] <= flash_q_reg & page_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pb_we)
        begin
            page_mem[pb_waddr] <= pb_wdata;
        end
        else if (ld_reg)
        begin
            page_mem[ld_idx_reg] <= ld_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_reg <= 1'b0;
            past_reg <= 1'b0;
            prog_reg <= 1'b0;
        end
        else
        begin
            ld_reg <= (cmd.op == DP_LOADPG);
            past_reg <= cmd.addr[AW];
            prog_reg <= (cmd.op == DP_PROG && !cmd.addr[AW]);
        end
    end

    always_ff @(posedge clk)
    begin
        ld_idx_reg <= cmd.pidx[PW-1:0];
        ld_data_reg <= cmd.addr[AW] ? 8'hFF : flash_mem[a];
        prog_addr_reg <= a;
    end

    assign stat.rdata = past_reg ? 8'hFF : flash_q_reg;
endmodule

@@ design/snf_ctrl.sv @@
// Command decoder and sequencer for the flash slave: handshake, phases, sweeps.
// Depends on snf_pkg and the assertion macro header.
`include "spi_nor_flash_slave_unit_assert.svh"
module snf_ctrl
    import snf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [63:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  logic [7:0]    data_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    reply_byte,
    output logic          reply_valid,
    output logic [1:0]    error_code,
    output dp_cmd_t       cmd,
    output logic          pb_we,
    output logic [PW-1:0] pb_waddr,
    output logic [7:0]    pb_wdata,
    input  dp_stat_t      stat
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RDWAIT, S_SWEEP, S_OUT
    } state_t;
    typedef enum logic [1:0] { PH_IDLE, PH_LOAD, PH_RUN } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [63:0] uid_reg;
    logic [7:0] cb_reg [COMMAND_LEN];
    logic [7:0] cb_next [COMMAND_LEN];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [7:0] last_reg, last_next;
    logic wel_reg, wel_next;
    logic [7:0] rb_reg, rb_next;
    logic rv_reg, rv_next;
    logic [1:0] err_reg, err_next;
    dp_op_t sop_reg, sop_next;
    logic [AW:0] sa_reg, sa_next;
    logic [AW:0] send_reg, send_next;
    logic [PW:0] si_reg, si_next;
    logic [23:0] addr_raw;
    logic [AW-1:0] addr_w;
    logic [7:0] op_c;
    logic [7:0] op_reg;
    logic [AW-1:0] base_pg;
    logic take;

    assign op_reg = cb_reg[0];
    assign in_ready = (state_reg == S_IDLE);
    assign take = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign reply_byte = rb_reg;
    assign reply_valid = rv_reg;
    assign error_code = err_reg;
    assign addr_raw = {cb_next[1], cb_next[2], cb_next[3]};
    assign addr_w = addr_raw[AW-1:0];
    assign base_pg = {cur_reg[AW-1:PW], {PW{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uid_reg <= '0;
        end
        else if (cfg_we)
        begin
            uid_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cb_next = cb_reg;
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        last_next = last_reg;
        wel_next = wel_reg;
        rb_next = rb_reg;
        rv_next = rv_reg;
        err_next = err_reg;
        sop_next = sop_reg;
        sa_next = sa_reg;
        send_next = send_reg;
        si_next = si_reg;
        op_c = cb_reg[0];
        cmd = '{op: DP_NONE, addr: '0, pidx: '0};
        pb_we = 1'b0;
        pb_waddr = cur_reg[PW-1:0];
        pb_wdata = data_byte;
        case (state_reg)
            S_CLEAR:
            begin
                cmd = '{op: DP_FILL, addr: sa_reg, pidx: '0};
                sa_next = sa_reg + 1'b1;
                if (sa_reg + 1'b1 == send_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    case (func)
                        FN_ASSERT:
                        begin
                            phase_next = PH_LOAD;
                            for (int i = 0; i < COMMAND_LEN; i++)
                            begin
                                cb_next[i] = '0;
                            end
                            cnt_next = '0;
                            last_next = '0;
                            cur_next = '0;
                        end
                        FN_RELEASE:
                        begin
                            phase_next = PH_IDLE;
                            if (phase_reg == PH_RUN)
                            begin
                                case (op_reg)
                                    OP_WREN: wel_next = 1'b1;
                                    OP_WRDI: wel_next = 1'b0;
                                    OP_PP, OP_CE, OP_CE2, OP_SE, OP_BE32, OP_BE64:
                                    begin
                                        if (wel_reg)
                                        begin
                                            wel_next = 1'b0;
                                            state_next = S_SWEEP;
                                            sop_next = DP_FILL;
                                            si_next = '0;
                                            case (op_reg)
                                                OP_PP:
                                                begin
                                                    sop_next = DP_PROG;
                                                    sa_next = {1'b0, base_pg};
                                                    send_next = {1'b0, base_pg}
                                                        + (AW+1)'(PAGE_BYTES);
                                                end
                                                OP_SE:
                                                begin
                                                    sa_next = {1'b0, cur_reg
                                                        & ~AW'(SECTOR_BYTES - 1)};
                                                    send_next = sa_next
                                                        + (AW+1)'(SECTOR_BYTES);
                                                end
                                                OP_BE32:
                                                begin
                                                    sa_next = {1'b0, cur_reg
                                                        & ~AW'(BLOCK32_BYTES - 1)};
                                                    send_next = sa_next
                                                        + (AW+1)'(BLOCK32_BYTES);
                                                end
                                                OP_BE64:
                                                begin
                                                    sa_next = {1'b0, cur_reg
                                                        & ~AW'(BLOCK64_BYTES - 1)};
                                                    send_next = sa_next
                                                        + (AW+1)'(BLOCK64_BYTES);
                                                end
                                                default:
                                                begin
                                                    sa_next = '0;
                                                    send_next = (AW+1)'(FLASH_BYTES);
                                                end
                                            endcase
                                            if (send_next > (AW+1)'(FLASH_BYTES))
                                            begin
                                                send_next = (AW+1)'(FLASH_BYTES);
                                            end
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        FN_BYTE:
                        begin
                            rb_next = last_reg;
                            rv_next = 1'b0;
                            err_next = ERR_NONE;
                            state_next = S_OUT;
                            case (phase_reg)
                                PH_LOAD:
                                begin
                                    if (cnt_reg >= CW'(COMMAND_LEN))
                                    begin
                                        err_next = ERR_LONG;
                                    end
                                    else
                                    begin
                                        cb_next[cnt_reg] = data_byte;
                                        cnt_next = cnt_reg + 1'b1;
                                        op_c = cb_next[0];
                                        case (op_c)
                                            OP_READ, OP_ID, OP_SE, OP_BE32, OP_BE64:
                                            begin
                                                if (cnt_next == CW'(4))
                                                begin
                                                    cur_next = addr_w;
                                                    phase_next = PH_RUN;
                                                end
                                            end
                                            OP_PP:
                                            begin
                                                if (cnt_next == CW'(4))
                                                begin
                                                    cur_next = addr_w;
                                                    phase_next = PH_RUN;
                                                    state_next = S_SWEEP;
                                                    sop_next = DP_LOADPG;
                                                    sa_next = {1'b0, addr_w[AW-1:PW],
                                                        {PW{1'b0}}};
                                                    send_next = sa_next
                                                        + (AW+1)'(PAGE_BYTES);
                                                    si_next = '0;
                                                end
                                            end
                                            OP_WREN, OP_WRDI, OP_RDSR, OP_CE, OP_CE2:
                                                phase_next = PH_RUN;
                                            OP_UID:
                                            begin
                                                if (cnt_next == CW'(5))
                                                begin
                                                    cur_next = AW'(8);
                                                    phase_next = PH_RUN;
                                                end
                                            end
                                            default: err_next = ERR_UNKNOWN;
                                        endcase
                                    end
                                end
                                PH_RUN:
                                begin
                                    case (op_reg)
                                        OP_ID:
                                        begin
                                            last_next = cur_reg[0] ? DEV_ID : MFR_ID;
                                            cur_next = cur_reg + 1'b1;
                                            rv_next = 1'b1;
                                            rb_next = last_next;
                                        end
                                        OP_READ:
                                        begin
                                            cmd = '{op: DP_READ, addr: {1'b0, cur_reg},
                                                pidx: '0};
                                            cur_next = cur_reg + 1'b1;
                                            rv_next = 1'b1;
                                            state_next = S_RDWAIT;
                                        end
                                        OP_RDSR:
                                        begin
                                            last_next = {6'd0, wel_reg, 1'b0};
                                            rv_next = 1'b1;
                                            rb_next = last_next;
                                        end
                                        OP_UID:
                                        begin
                                            if (cur_reg != '0 && cur_reg <= AW'(8))
                                            begin
                                                last_next = uid_reg[8*(cur_reg[3:0]-4'd1)
                                                    +: 8];
                                                cur_next = cur_reg - 1'b1;
                                                rv_next = 1'b1;
                                                rb_next = last_next;
                                            end
                                        end
                                        OP_PP:
                                        begin
                                            pb_we = 1'b1;
                                            cur_next = {cur_reg[AW-1:PW],
                                                cur_reg[PW-1:0] + 1'b1};
                                        end
                                        default: ;
                                    endcase
                                end
                                default:
                                begin
                                    rb_next = '0;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT:
            begin
                state_next = S_OUT;
                rb_next = stat.rdata;
                last_next = stat.rdata;
            end
            S_SWEEP:
            begin
                cmd = '{op: sop_reg, addr: sa_reg, pidx: si_reg};
                sa_next = sa_reg + 1'b1;
                si_next = si_reg + 1'b1;
                if (sa_reg + 1'b1 == send_reg || (sop_reg != DP_FILL
                    && si_reg == (PW+1)'(PAGE_BYTES - 1)))
                begin
                    state_next = (sop_reg == DP_LOADPG) ? S_OUT : S_IDLE;
                end
                if (sop_reg == DP_LOADPG)
                begin
                    cmd.addr = sa_reg;
                    if (sa_reg >= (AW+1)'(FLASH_BYTES))
                    begin
                        cmd.addr = {1'b1, sa_reg[AW-1:0]};
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_IDLE;
            for (int i = 0; i < COMMAND_LEN; i++)
            begin
                cb_reg[i] <= '0;
            end
            cnt_reg <= '0;
            cur_reg <= '0;
            last_reg <= '0;
            wel_reg <= 1'b0;
            rb_reg <= '0;
            rv_reg <= 1'b0;
            err_reg <= '0;
            sop_reg <= DP_NONE;
            sa_reg <= '0;
            send_reg <= (AW+1)'(FLASH_BYTES);
            si_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cb_reg <= cb_next;
            cnt_reg <= cnt_next;
            cur_reg <= cur_next;
            last_reg <= last_next;
            wel_reg <= wel_next;
            rb_reg <= rb_next;
            rv_reg <= rv_next;
            err_reg <= err_next;
            sop_reg <= sop_next;
            sa_reg <= sa_next;
            send_reg <= send_next;
            si_reg <= si_next;
        end
    end

    `SNF_ASSERT_IMPL(a_err_no_reply, out_valid && error_code != ERR_NONE, !reply_valid)
    `SNF_ASSERT_NEXT(a_rdwait_out, state_reg == S_RDWAIT, state_reg == S_OUT)
    `SNF_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CW'(COMMAND_LEN))
endmodule

@@ design/spi_nor_flash_slave_unit.sv @@
// SPI NOR flash slave (W25X-style command set) top level.
// Depends on snf_pkg, snf_ctrl, snf_datapath.
// One word in, at most one word out; a data read passes through a wait state for the
// registered array read. After reset the array is cleared to 0xFF by a pass over all
// FLASH_BYTES addresses before any word is taken. At chip-select release a program walks
// the page (the last write landing after the walk, from registers) and an erase walks its
// region one byte a cycle (the whole array for chip erase); the page load at the fourth
// byte of a page program walks the page too.
module spi_nor_flash_slave_unit
    import snf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  reply_byte,
    output logic        reply_valid,
    output logic [1:0]  error_code
);
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic pb_we;
    logic [PW-1:0] pb_waddr;
    logic [7:0] pb_wdata;

    snf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .reply_byte(reply_byte),
        .reply_valid(reply_valid), .error_code(error_code), .cmd(cmd),
        .pb_we(pb_we), .pb_waddr(pb_waddr), .pb_wdata(pb_wdata), .stat(stat)
    );

    snf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .pb_we(pb_we), .pb_waddr(pb_waddr),
        .pb_wdata(pb_wdata), .stat(stat)
    );
endmodule
